// ===== hdl/jsd_pkg.sv =====
// jsd_pkg: shared widths, register indexes and the entry update struct
// for the joint stall detector; no dependencies
package jsd_pkg;

  localparam int MAX_JOINTS_DEF = 16;
  localparam int JIDX_W         = 4;
  localparam int POS_W          = 32;
  localparam int EFF_W          = 32;
  localparam int LIMIT_W        = 31;
  localparam int CLASS_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int ENTRY_W        = POS_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_EPS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFF_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVIDENCE_CLASS = 2'd2;

  // per-item outcome of the evaluation logic
  typedef struct packed {
    logic                    in_range;
    logic                    new_high;
    logic signed [POS_W-1:0] new_pos;
    logic                    stall_hit;
  } jsd_upd_t;

endpackage

// ===== hdl/joint_stall_detector.sv =====
// joint_stall_detector: one item per cycle while not stalled; entry read in the
// accept cycle, evaluated and written back from the input register, result held
// in an output register. a window_end result passes the input register, then
// the output register when out_stall lets it; throughput is set by the single
// entry ram read/write with forwarding. synchronous active-low reset clears
// control state, stall flag and output registers; entries undefined until written
module joint_stall_detector
  import jsd_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [JIDX_W-1:0]       in_joint_index,
  input  logic signed [POS_W-1:0] in_position,
  input  logic signed [EFF_W-1:0] in_effort,
  input  logic                    in_first_sample,
  input  logic                    in_last_sample,
  input  logic                    in_window_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_stalled,
  output logic [CLASS_W-1:0]      out_evidence_class_res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [LIMIT_W-1:0]      cfg_wdata
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [LIMIT_W-1:0] pos_eps_r;
  logic [LIMIT_W-1:0] eff_bound_r;
  logic [CLASS_W-1:0] ev_class_r;

  logic                    s1_valid_r;
  logic [JIDX_W-1:0]       s1_joint_r;
  logic signed [POS_W-1:0] s1_pos_r;
  logic signed [EFF_W-1:0] s1_eff_r;
  logic                    s1_first_r;
  logic                    s1_last_r;
  logic                    s1_wend_r;
  logic                    byp_sel_r;
  logic [ENTRY_W-1:0]      byp_data_r;
  logic                    stall_found_r;
  logic                    out_valid_r;
  logic                    out_stalled_r;
  logic [CLASS_W-1:0]      out_class_r;

  logic               in_acc;
  logic               s1_fire;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] cur_entry;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  jsd_upd_t           upd;

  // config registers, written only while idle; the user is bound, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_eps_r   <= '0;
      eff_bound_r <= '0;
      ev_class_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_EPS:        pos_eps_r   <= cfg_wdata;
        CFG_EFF_LIMIT:      eff_bound_r <= cfg_wdata;
        CFG_EVIDENCE_CLASS: ev_class_r  <= cfg_wdata[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // only a window_end item needs the output register
  assign s1_fire  = s1_valid_r & (~s1_wend_r | ~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_fire;
  assign in_acc   = in_valid & ~in_stall;

  assign wr_en   = s1_fire & upd.in_range;
  assign wr_data = {upd.new_high, upd.new_pos};

  jsd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_JOINTS)
  ) u_entries (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(s1_joint_r)),
    .wdata(wr_data),
    .re   (in_acc),
    .raddr(AW'(in_joint_index)),
    .rdata(rd_data)
  );

  // the ram read misses a write to the same joint in the accept cycle
  assign cur_entry = byp_sel_r ? byp_data_r : rd_data;

  jsd_eval #(
    .MAX_JOINTS(MAX_JOINTS)
  ) u_eval (
    .joint_index (s1_joint_r),
    .position    (s1_pos_r),
    .effort      (s1_eff_r),
    .first_sample(s1_first_r),
    .last_sample (s1_last_r),
    .old_high    (cur_entry[ENTRY_W-1]),
    .old_pos     (cur_entry[POS_W-1:0]),
    .pos_eps     (pos_eps_r),
    .eff_limit   (eff_bound_r),
    .upd         (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_sel_r  <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      byp_sel_r  <= wr_en & (s1_joint_r == in_joint_index);
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_joint_r <= in_joint_index;
      s1_pos_r   <= in_position;
      s1_eff_r   <= in_effort;
      s1_first_r <= in_first_sample;
      s1_last_r  <= in_last_sample;
      s1_wend_r  <= in_window_end;
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_found_r <= 1'b0;
    end else if (s1_fire) begin
      stall_found_r <= s1_wend_r ? 1'b0 : (stall_found_r | upd.stall_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_stalled_r <= 1'b0;
      out_class_r   <= '0;
    end else if (s1_fire & s1_wend_r) begin
      out_valid_r   <= 1'b1;
      out_stalled_r <= stall_found_r | upd.stall_hit;
      out_class_r   <= ev_class_r;
    end else if (!out_stall) begin
      out_valid_r   <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_stalled            = out_stalled_r;
  assign out_evidence_class_res = out_class_r;

endmodule

// ===== hdl/jsd_ram.sv =====
// jsd_ram: generic single write port, single read port ram with registered read
// no dependencies
module jsd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/jsd_eval.sv =====
// jsd_eval: combinational per-item evaluation of one joint entry
// depends on jsd_pkg
module jsd_eval
  import jsd_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic [JIDX_W-1:0]       joint_index,
  input  logic signed [POS_W-1:0] position,
  input  logic signed [EFF_W-1:0] effort,
  input  logic                    first_sample,
  input  logic                    last_sample,
  input  logic                    old_high,
  input  logic signed [POS_W-1:0] old_pos,
  input  logic [LIMIT_W-1:0]      pos_eps,
  input  logic [LIMIT_W-1:0]      eff_limit,
  output jsd_upd_t                upd
);

  localparam logic [8:0] JOINTS_LIM = 9'(MAX_JOINTS);

  logic             in_range;
  logic [EFF_W-1:0] eff_mag;
  logic             eff_low;
  logic             high_now;
  logic [POS_W:0]   diff;
  logic [POS_W:0]   diff_mag;
  logic             unmoved;

  always_comb begin
    in_range = {{(9 - JIDX_W){1'b0}}, joint_index} < JOINTS_LIM;
    // most negative effort gives 2^31, which still fits unsigned
    eff_mag  = effort[EFF_W-1] ? (~effort + 1'b1) : effort;
    eff_low  = eff_mag < {1'b0, eff_limit};
    high_now = (first_sample | old_high) & ~eff_low;
    diff     = {position[POS_W-1], position} - {old_pos[POS_W-1], old_pos};
    diff_mag = diff[POS_W] ? (~diff + 1'b1) : diff;
    unmoved  = diff_mag < {2'b00, pos_eps};

    upd.in_range  = in_range;
    upd.new_high  = high_now;
    upd.new_pos   = first_sample ? position : old_pos;
    upd.stall_hit = in_range & last_sample & ~first_sample & unmoved & high_now;
  end

endmodule

// ===== hdl/jsd_checker.sv =====
// jsd_checker: port-level checks on the joint stall detector, bound to the top
// depends on jsd_pkg and joint_stall_detector
module jsd_checker
  import jsd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_window_end,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_stalled,
  input logic [CLASS_W-1:0] out_evidence_class_res
);

  logic in_xfer;
  assign in_xfer = in_valid & ~in_stall;

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or stall active after reset");

  // input backs up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result");

  // a window_end transfer reaches the output once the output is free
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_window_end) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("window result missing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_stalled) && $stable(out_evidence_class_res)))
    else $error("stalled result changed");

endmodule

bind joint_stall_detector jsd_checker u_jsd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .in_window_end         (in_window_end),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_stalled           (out_stalled),
  .out_evidence_class_res(out_evidence_class_res)
);

// ===== bench/joint_stall_detector_tb.sv =====
`timescale 1ns / 100ps
// joint_stall_detector_tb: self-checking bench for the joint stall detector,
// a scoreboard class predicts one stall verdict per window from the accepted
// samples; depends on jsd_pkg and joint_stall_detector
module joint_stall_detector_tb;
  import jsd_pkg::*;

  // index past the register list, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int JOINTS = MAX_JOINTS_DEF;

  typedef struct {
    logic [JIDX_W-1:0]       joint;
    logic signed [POS_W-1:0] pos;
    logic signed [EFF_W-1:0] eff;
    logic                    first;
    logic                    last;
    logic                    wend;
  } joint_sample_t;

  typedef struct {
    logic               stalled;
    logic [CLASS_W-1:0] cls;
  } verdict_t;

  class stall_scoreboard;
    logic signed [POS_W-1:0] origin_pos [JOINTS];
    logic                    effort_ok  [JOINTS];
    logic                    stall_seen;
    logic [LIMIT_W-1:0]      eps;
    logic [LIMIT_W-1:0]      bound;
    logic [CLASS_W-1:0]      cls;
    verdict_t                verdicts[$];
    int                      errors;

    function new();
      stall_seen = 1'b0;
      eps        = '0;
      bound      = '0;
      cls        = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        CFG_POS_EPS:        eps = val;
        CFG_EFF_LIMIT:      bound = val;
        CFG_EVIDENCE_CLASS: cls = val[CLASS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    function void note_sample(joint_sample_t s);
      longint mag;
      longint delta;
      verdict_t v;
      if (int'(s.joint) < JOINTS) begin
        if (s.first) begin
          origin_pos[s.joint] = s.pos;
          effort_ok[s.joint]  = 1'b1;
        end
        mag = longint'(s.eff);
        if (mag < 0) mag = -mag;
        if (mag < longint'(bound)) effort_ok[s.joint] = 1'b0;
        // exact 33-bit difference, no wrap
        if (s.last && !s.first) begin
          delta = longint'(s.pos) - longint'(origin_pos[s.joint]);
          if (delta < 0) delta = -delta;
          if (delta < longint'(eps) && effort_ok[s.joint]) stall_seen = 1'b1;
        end
      end
      if (s.wend) begin
        v.stalled = stall_seen;
        v.cls     = cls;
        verdicts.push_back(v);
        stall_seen = 1'b0;
      end
    endfunction

    task check_verdict(logic stalled, logic [CLASS_W-1:0] cls_res);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report($sformatf("result with nothing expected (stalled=%0b class=%0d)",
                         stalled, cls_res));
      end else begin
        v = verdicts.pop_front();
        if (stalled !== v.stalled)
          report($sformatf("stalled %0b, expected %0b", stalled, v.stalled));
        if (cls_res !== v.cls)
          report($sformatf("evidence class %0d, expected %0d", cls_res, v.cls));
      end
    endtask

    task flush_check();
      if (verdicts.size() != 0)
        report($sformatf("%0d expected results never arrived", verdicts.size()));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [JIDX_W-1:0]       in_joint_index = '0;
  logic signed [POS_W-1:0] in_position = '0;
  logic signed [EFF_W-1:0] in_effort = '0;
  logic                    in_first_sample = 1'b0;
  logic                    in_last_sample = 1'b0;
  logic                    in_window_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_stalled;
  logic [CLASS_W-1:0]      out_evidence_class_res;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [LIMIT_W-1:0]      cfg_wdata = '0;

  stall_scoreboard sb;
  joint_sample_t   feed[$];
  bit              item_held = 1'b0;
  bit              hold_req = 1'b0;
  bit              seeded [JOINTS];
  int              queued = 0;
  logic [LIMIT_W-1:0] cur_eps = '0;
  logic [LIMIT_W-1:0] cur_bound = '0;

  joint_stall_detector u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_joint_index         (in_joint_index),
    .in_position            (in_position),
    .in_effort              (in_effort),
    .in_first_sample        (in_first_sample),
    .in_last_sample         (in_last_sample),
    .in_window_end          (in_window_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_stalled            (out_stalled),
    .out_evidence_class_res (out_evidence_class_res),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  initial begin : sender
    joint_sample_t cur;
    int burst_left;
    int gap_left;
    burst_left = 8;
    gap_left   = 0;
    cur = '{default: '0};
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        sb.note_sample(cur);
        item_held = 1'b0;
      end
      if (!item_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed.size() != 0) begin
          cur = feed.pop_front();
          item_held = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      in_valid        <= item_held;
      in_joint_index  <= cur.joint;
      in_position     <= cur.pos;
      in_effort       <= cur.eff;
      in_first_sample <= cur.first;
      in_last_sample  <= cur.last;
      in_window_end   <= cur.wend;
    end
  end

  // receiver: stall pattern switches between four modes, picked at random
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    int hold_left;
    mode = 0;
    mode_left = 20;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_verdict(out_stalled, out_evidence_class_res);
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 64);
      end else begin
        mode_left--;
      end
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ((tick % 5) < 2);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // timeout, well past the slowest run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task push_sample(int j, logic [31:0] pos, logic [31:0] eff, bit f, bit l, bit w);
    joint_sample_t s;
    s.joint = j[JIDX_W-1:0];
    s.pos   = pos;
    s.eff   = eff;
    s.first = f;
    s.last  = l;
    s.wend  = w;
    if (f) seeded[j] = 1'b1;
    feed.push_back(s);
    queued++;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task apply_settings(logic [LIMIT_W-1:0] eps, logic [LIMIT_W-1:0] bound,
                      logic [CLASS_W-1:0] cls);
    write_reg(CFG_POS_EPS, eps);
    write_reg(CFG_EFF_LIMIT, bound);
    write_reg(CFG_EVIDENCE_CLASS, {{(LIMIT_W-CLASS_W){1'b0}}, cls});
    cur_eps   = eps;
    cur_bound = bound;
  endtask

  // all results in, then a wait for items that produce none
  task wait_idle();
    while (feed.size() != 0 || item_held || sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function logic [31:0] effort_value(bit low_eff);
    longint mag;
    logic [31:0] v;
    if (low_eff && cur_bound != 0) mag = $urandom_range(0, cur_bound - 1);
    else if ($urandom_range(0, 15) == 0) mag = 64'h8000_0000;
    else mag = $urandom_range(cur_bound, 32'h7FFF_FFFF);
    v = mag[31:0];
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task queue_window(int joint_cnt, int sample_cnt);
    int jl [JOINTS];
    logic [31:0] base [JOINTS];
    logic [31:0] delta;
    longint lim;
    int k;
    int t;
    bit near;
    for (int i = 0; i < JOINTS; i++) jl[i] = i;
    for (int i = JOINTS - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = jl[i];
      jl[i] = jl[k];
      jl[k] = t;
    end
    near = ($urandom_range(0, 9) < 7);
    lim  = longint'(cur_eps) + longint'(cur_eps) / 4 + 2;
    for (int s = 0; s < sample_cnt; s++) begin
      for (int i = 0; i < joint_cnt; i++) begin
        if (s == 0) begin
          base[jl[i]] = $urandom;
          push_sample(jl[i], base[jl[i]], effort_value($urandom_range(0, 9) == 0),
                      1'b1, sample_cnt == 1, (sample_cnt == 1) && (i == joint_cnt - 1));
        end else begin
          delta = near ? $urandom_range(0, lim[31:0]) : $urandom;
          if ($urandom_range(0, 1)) delta = -delta;
          push_sample(jl[i], base[jl[i]] + delta, effort_value($urandom_range(0, 9) == 0),
                      1'b0, s == sample_cnt - 1,
                      (s == sample_cnt - 1) && (i == joint_cnt - 1));
        end
      end
    end
  endtask

  // loose items with random flags; a joint never seen is always seeded first
  task queue_noise(int n);
    int j;
    bit f;
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(0, JOINTS - 1);
      f = ($urandom_range(0, 1) != 0);
      if (!seeded[j]) f = 1'b1;
      push_sample(j, $urandom, $urandom, f, $urandom_range(0, 1) != 0,
                  $urandom_range(0, 3) == 0);
    end
  endtask

  task run_random(int budget);
    int stop;
    stop = queued + budget;
    while (queued < stop) begin
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 6));
      else queue_window(($urandom_range(0, 9) == 0) ? $urandom_range(5, JOINTS)
                                                    : $urandom_range(1, 4),
                        $urandom_range(1, 4));
    end
  endtask

  initial begin : main
    sb = new();
    for (int i = 0; i < JOINTS; i++) seeded[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero epsilon never reports a stall
    push_sample(0, $urandom, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    push_sample(0, $urandom, 32'h8000_0000, 1'b0, 1'b1, 1'b1);
    wait_idle();

    apply_settings(31'h0001_0000, 31'h0000_8000, 8'hA5);
    write_reg(CFG_SPARE, 31'h7FFF_FFFF);
    // extreme position and most negative effort, unmoved
    push_sample(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    push_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 1'b1);
    // full-scale move, effort exactly at the bound
    push_sample(1, 32'h8000_0000, 32'h0000_8000, 1'b1, 1'b0, 1'b0);
    push_sample(1, 32'h7FFF_FFFF, 32'hFFFF_8000, 1'b0, 1'b1, 1'b1);
    // weak effort on a middle sample clears the mark
    push_sample(2, 32'd100, 32'h0001_0000, 1'b1, 1'b0, 1'b0);
    push_sample(2, 32'd100, 32'hFFFF_8001, 1'b0, 1'b0, 1'b0);
    push_sample(2, 32'd100, 32'h0001_0000, 1'b0, 1'b1, 1'b1);
    // first and last in one item: no stall test
    push_sample(3, 32'd5, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
    // move of exactly epsilon vs one less
    push_sample(4, -32'sd5, 32'h0002_0000, 1'b1, 1'b0, 1'b0);
    push_sample(5, 32'd0, 32'h0002_0000, 1'b1, 1'b0, 1'b0);
    push_sample(4, 32'h0000_FFFB, 32'h0002_0000, 1'b0, 1'b1, 1'b0);
    push_sample(5, 32'hFFFF_0001, 32'h0002_0000, 1'b0, 1'b1, 1'b1);
    // weak effort on the last sample itself
    push_sample(6, 32'd0, 32'h0000_8000, 1'b1, 1'b0, 1'b0);
    push_sample(6, 32'd0, 32'h0000_7FFF, 1'b0, 1'b1, 1'b1);
    // flag must be clear again after the previous window end
    push_sample(0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
    push_sample(0, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1);
    wait_idle();

    apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
    push_sample(7, 32'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
    push_sample(7, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1);
    push_sample(8, 32'd0, 32'h7FFF_FFFE, 1'b1, 1'b0, 1'b0);
    push_sample(8, 32'd0, 32'h8000_0000, 1'b0, 1'b1, 1'b1);
    // window end on a first-sample-only item
    push_sample(9, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
    run_random(70);
    wait_idle();

    apply_settings('0, '0, '0);
    run_random(70);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      apply_settings(31'($urandom_range(1, 32'h0004_0000)),
                     31'($urandom_range(0, 32'h0010_0000)),
                     8'($urandom_range(0, 255)));
      if (p == 0) begin
        // long receiver hold while single-item windows keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) queue_window(1, 1);
        wait_idle();
      end
      run_random(38);
      if (p == 1) wait_idle();
      run_random(38);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
